// ===== rtl/core/nhmf_pkg.sv =====
// Shared widths, register indexes, fixed-point constants and helpers for the relaxation-rate evaluator.
package nhmf_pkg;

  localparam int TAU_BITS  = 20;
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 11;
  localparam int SPIN_W    = 18;
  localparam int S2_W      = 17;
  localparam int RATE_W    = 32;
  localparam int CFG_W     = 18;
  localparam int IDX_W     = 2;

  localparam int X_W   = 48;
  localparam int L_W   = 32;
  localparam int SUM_W = 38;
  localparam int FA_W  = 20;
  localparam int F2_W  = 2 * FIELD_W;
  localparam int P_W   = FIELD_W + TAU_BITS;
  localparam int FT_W  = FA_W + TAU_BITS;
  localparam int U_W   = TAU_BITS + S2_W;
  localparam int VD_W  = U_W + SUM_W - 30;
  localparam int SH    = 76 - FRAC_BITS;

  localparam int MUL_LAT = 2;
  localparam int LOR_LAT = 33;

  localparam logic [IDX_W-1:0] REG_FIELD = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOCK  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SPIN  = 2'd2;

  localparam logic [FIELD_W-1:0] FIELD_RST = 11'd600;
  localparam logic [S2_W-1:0]    S2_ONE    = 17'd65536;

  localparam logic [63:0] KH_Q48 = 64'd1768559438;
  localparam logic [63:0] KN_Q48 = 64'd179191101;
  localparam logic [63:0] KS_Q64 = 64'd115904311;
  localparam logic [63:0] A1_Q60 = 64'd599077307000000;
  localparam logic [63:0] A2_Q60 = 64'd99846217833333;
  localparam logic [63:0] B1_Q60 = 64'd1800485440;
  localparam logic [63:0] B2_Q60 = 64'd100026969;

  typedef logic [63:0]  opnd_t;
  typedef logic [127:0] prod_t;

  function automatic prod_t rnd_shr(input prod_t p, input int s);
    prod_t one;
    one = 128'd1;
    return (p + (one << (s - 1))) >> s;
  endfunction

endpackage

// ===== rtl/core/nhmf_mul.sv =====
// Two-stage 64 by 64 multiplier built from four registered 32 by 32 partial products.
module nhmf_mul import nhmf_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  opnd_t a,
  input  opnd_t b,
  output prod_t p
);

  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  prod_t       p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      lh_r <= a[31:0] * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      hh_r <= a[63:32] * b[63:32];
      p_r  <= {hh_r, ll_r} + ({64'd0, lh_r} << 32) + ({64'd0, hl_r} << 32);
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/nhmf_lor.sv =====
// Lorentzian 1/(1+x^2) in Q1.31: squaring stage followed by a one-bit-per-stage restoring divider.
module nhmf_lor import nhmf_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [X_W-1:0] x,
  output logic [L_W-1:0] l
);

  logic [61:0] sq;
  logic [63:0] den_nxt;
  logic [63:0] rem0;
  logic [63:0] den_s [0:31];
  logic [63:0] rem_s [1:31];
  logic [31:0] q_s   [1:32];

  always_comb begin
    sq = x[30:0] * x[30:0];
    if (|x[X_W-1:31]) begin
      den_nxt = 64'h8000_0000_0000_0000;
    end else begin
      den_nxt = 64'h1_0000_0000 + {2'b00, sq};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s[0] <= den_nxt;
    end
  end

  assign rem0 = {32'd0, 1'b1, den_s[0][63:33]};

  genvar j;
  generate
    for (j = 1; j <= 32; j++) begin : g_step
      logic [63:0] rin;
      logic [31:0] qin;
      logic [64:0] sh;
      logic [64:0] df;
      logic        ge;
      if (j == 1) begin : g_first
        assign rin = rem0;
        assign qin = 32'd0;
      end else begin : g_next
        assign rin = rem_s[j-1];
        assign qin = q_s[j-1];
      end
      assign sh = {rin, den_s[j-1][33-j]};
      assign ge = (sh >= {1'b0, den_s[j-1]});
      assign df = ge ? (sh - {1'b0, den_s[j-1]}) : sh;
      always_ff @(posedge clk) begin
        if (en) begin
          q_s[j] <= {qin[30:0], ge};
        end
      end
      if (j < 32) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_s[j] <= df[63:0];
            den_s[j] <= den_s[j-1];
          end
        end
      end
    end
  endgenerate

  assign l = q_s[32];

endmodule

// ===== rtl/core/nh_model_free_relaxation_rates.sv =====
// Model-free 15N R1/R2 evaluator: top level with configuration, pipeline and output skid.
// Takes one (tau, S2) word per cycle while in_stall is low and returns R1 and R2 for each word, in order.
// Most of the depth is in the eight Lorentzian units, each a 32-stage restoring divider, plus
// three two-stage multiplier banks. Configuration is read live by the pipeline, so write it
// only while no word is in flight. A two-entry output (register plus skid) lets the pipeline
// keep advancing for one word after out_stall rises; in_stall is high while the skid is full.
module nh_model_free_relaxation_rates import nhmf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TAU_BITS-1:0] in_tau_ps,
  input  logic [S2_W-1:0]     in_order_param,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RATE_W-1:0]   out_r1_rate,
  output logic [RATE_W-1:0]   out_r2_rate,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int L_I   = 7 + LOR_LAT;
  localparam int N_LVL = L_I + 2 * MUL_LAT + 2;
  localparam int U_DLY = L_I - 2;

  logic [FIELD_W-1:0] field_r;
  logic [SPIN_W-1:0]  lock_r, spin_r;

  logic en;
  logic v_r [0:N_LVL-1];

  logic [TAU_BITS-1:0] tau_a_r;
  logic [S2_W-1:0]     q_a_r, q_nxt;

  logic signed [21:0]  fs [0:3];
  logic [FA_W-1:0]     fa [0:3];
  logic [P_W-1:0]      p_b_r;
  logic [U_W-1:0]      u_b_r;
  logic [FT_W-1:0]     ft_b_r [0:3];

  prod_t               ph, pn;
  prod_t               ps [0:3];
  logic [X_W-1:0]      xh_e_r, xn_e_r;
  logic [X_W-1:0]      xs_e_r [0:3];
  logic [X_W-1:0]      x_f_r [0:7];
  logic [L_W-1:0]      lo [0:7];

  logic [SUM_W-1:0]    le [0:7];
  logic [SUM_W-1:0]    s3, d1_nxt, d2_nxt, c2_nxt;
  logic [SUM_W-1:0]    d1_i_r, d2_i_r, c2_i_r, ln_i_r;
  logic [U_W-1:0]      u_d_r [0:U_DLY-1];

  prod_t               pd1, pc1, pd2, pc2;
  logic [VD_W-1:0]     vd1_l_r, vc1_l_r, vd2_l_r, vc2_l_r;
  logic [F2_W-1:0]     f2_r;
  logic [63:0]         cc1_r, cc2_r;
  prod_t               ra1, rb1, ra2, rb2;
  logic [128:0]        r1_sum, r2_sum;
  logic [RATE_W-1:0]   r1_o_r, r2_o_r;

  logic                out_valid_r, skid_v_r, out_free;
  logic [RATE_W-1:0]   out_r1_r, out_r2_r, skid_r1_r, skid_r2_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= FIELD_RST;
      lock_r  <= '0;
      spin_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD: field_r <= cfg_data[FIELD_W-1:0];
        REG_LOCK:  lock_r  <= cfg_data[SPIN_W-1:0];
        REG_SPIN:  spin_r  <= cfg_data[SPIN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    f2_r  <= field_r * field_r;
    cc1_r <= 64'(B1_Q60 * 64'(f2_r));
    cc2_r <= 64'(B2_Q60 * 64'(f2_r));
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_LVL; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < N_LVL; k++) v_r[k] <= v_r[k-1];
    end
  end

  // stage a: capture word, form 1-S2
  assign q_nxt = (in_order_param > S2_ONE) ? '0 : S2_ONE - in_order_param;

  always_ff @(posedge clk) begin
    if (en) begin
      tau_a_r <= in_tau_ps;
      q_a_r   <= q_nxt;
    end
  end

  // stage b: small products and sideband offsets
  always_comb begin
    fs[0] = $signed({4'b0, lock_r}) - $signed({3'b0, spin_r, 1'b0});
    fs[1] = $signed({4'b0, lock_r}) + $signed({3'b0, spin_r, 1'b0});
    fs[2] = $signed({4'b0, lock_r}) - $signed({4'b0, spin_r});
    fs[3] = $signed({4'b0, lock_r}) + $signed({4'b0, spin_r});
    for (int k = 0; k < 4; k++) begin
      fa[k] = fs[k][21] ? FA_W'(-fs[k]) : FA_W'(fs[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_b_r <= field_r * tau_a_r;
      u_b_r <= tau_a_r * q_a_r;
      for (int k = 0; k < 4; k++) ft_b_r[k] <= fa[k] * tau_a_r;
    end
  end

  // stages c, d: frequency scaling
  nhmf_mul u_mul_h (.clk(clk), .en(en), .a(64'(p_b_r)), .b(KH_Q48), .p(ph));
  nhmf_mul u_mul_n (.clk(clk), .en(en), .a(64'(p_b_r)), .b(KN_Q48), .p(pn));

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_side
      nhmf_mul u_mul_s (.clk(clk), .en(en), .a(64'(ft_b_r[g])), .b(KS_Q64), .p(ps[g]));
    end
  endgenerate

  // stage e: round to Q.16
  always_ff @(posedge clk) begin
    if (en) begin
      xh_e_r <= X_W'(rnd_shr(ph, 32));
      xn_e_r <= X_W'(rnd_shr(pn, 32));
      for (int k = 0; k < 4; k++) xs_e_r[k] <= X_W'(rnd_shr(ps[k], 48));
    end
  end

  // stage f: the eight arguments
  always_ff @(posedge clk) begin
    if (en) begin
      x_f_r[0] <= xh_e_r;
      x_f_r[1] <= xn_e_r;
      x_f_r[2] <= xh_e_r + xn_e_r;
      x_f_r[3] <= (xh_e_r >= xn_e_r) ? xh_e_r - xn_e_r : '0;
      for (int k = 0; k < 4; k++) x_f_r[4+k] <= xs_e_r[k];
    end
  end

  generate
    for (g = 0; g < 8; g++) begin : g_lor
      nhmf_lor u_lor (.clk(clk), .en(en), .x(x_f_r[g]), .l(lo[g]));
    end
  endgenerate

  // hold 1-S2 scaled tau alongside the divider chain
  always_ff @(posedge clk) begin
    if (en) begin
      u_d_r[0] <= u_b_r;
      for (int k = 1; k < U_DLY; k++) u_d_r[k] <= u_d_r[k-1];
    end
  end

  // stage i: weighted sums
  always_comb begin
    for (int k = 0; k < 8; k++) le[k] = SUM_W'(lo[k]);
    s3     = ((le[4] + le[5]) << 1) + ((le[6] + le[7]) << 2);
    d1_nxt = le[3] + SUM_W'(3) * le[1] + SUM_W'(6) * le[2];
    c2_nxt = s3 + SUM_W'(9) * le[1];
    d2_nxt = c2_nxt + SUM_W'(3) * le[3] + SUM_W'(18) * (le[0] + le[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_i_r <= d1_nxt;
      d2_i_r <= d2_nxt;
      c2_i_r <= c2_nxt;
      ln_i_r <= le[1];
    end
  end

  nhmf_mul u_mul_d1 (.clk(clk), .en(en), .a(64'(u_d_r[U_DLY-1])), .b(64'(d1_i_r)), .p(pd1));
  nhmf_mul u_mul_c1 (.clk(clk), .en(en), .a(64'(u_d_r[U_DLY-1])), .b(64'(ln_i_r)), .p(pc1));
  nhmf_mul u_mul_d2 (.clk(clk), .en(en), .a(64'(u_d_r[U_DLY-1])), .b(64'(d2_i_r)), .p(pd2));
  nhmf_mul u_mul_c2 (.clk(clk), .en(en), .a(64'(u_d_r[U_DLY-1])), .b(64'(c2_i_r)), .p(pc2));

  always_ff @(posedge clk) begin
    if (en) begin
      vd1_l_r <= VD_W'(rnd_shr(pd1, 31));
      vc1_l_r <= VD_W'(rnd_shr(pc1, 31));
      vd2_l_r <= VD_W'(rnd_shr(pd2, 31));
      vc2_l_r <= VD_W'(rnd_shr(pc2, 31));
    end
  end

  nhmf_mul u_mul_a1 (.clk(clk), .en(en), .a(64'(vd1_l_r)), .b(A1_Q60), .p(ra1));
  nhmf_mul u_mul_b1 (.clk(clk), .en(en), .a(64'(vc1_l_r)), .b(cc1_r),  .p(rb1));
  nhmf_mul u_mul_a2 (.clk(clk), .en(en), .a(64'(vd2_l_r)), .b(A2_Q60), .p(ra2));
  nhmf_mul u_mul_b2 (.clk(clk), .en(en), .a(64'(vc2_l_r)), .b(cc2_r),  .p(rb2));

  // stage o: scale, add, saturate
  assign r1_sum = {1'b0, rnd_shr(ra1, SH)} + {1'b0, rnd_shr(rb1, SH)};
  assign r2_sum = {1'b0, rnd_shr(ra2, SH)} + {1'b0, rnd_shr(rb2, SH)};

  always_ff @(posedge clk) begin
    if (en) begin
      r1_o_r <= (|r1_sum[128:RATE_W]) ? '1 : r1_sum[RATE_W-1:0];
      r2_o_r <= (|r2_sum[128:RATE_W]) ? '1 : r2_sum[RATE_W-1:0];
    end
  end

  // output register and skid
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end
    end else if (v_r[N_LVL-1]) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) begin
        out_r1_r <= skid_r1_r;
        out_r2_r <= skid_r2_r;
      end
    end else if (v_r[N_LVL-1]) begin
      if (out_free) begin
        out_r1_r <= r1_o_r;
        out_r2_r <= r2_o_r;
      end else begin
        skid_r1_r <= r1_o_r;
        skid_r2_r <= r2_o_r;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_r1_rate = out_r1_r;
  assign out_r2_rate = out_r2_r;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid word without output word");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_valid_r && out_stall) |=> skid_v_r)
    else $error("skid word dropped while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted word missing from first stage");

  a_spill_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[N_LVL-1] && !skid_v_r && out_valid_r && out_stall) |=> skid_v_r)
    else $error("finished word lost under output stall");
`endif

endmodule

// ===== test/nh_model_free_relaxation_rates_tb.sv =====
// Self-checking testbench for the model-free 15N R1/R2 relaxation-rate evaluator.
module nh_model_free_relaxation_rates_tb;
  import nhmf_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic [RATE_W-1:0] r1;
    logic [RATE_W-1:0] r2;
  } rates_t;

  class rate_board;
    rates_t pending[$];
    logic [63:0] field, lock, spin;
    int errors;

    function new();
      field = 64'(FIELD_RST);
      lock = 0;
      spin = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FIELD: field = 64'(val[FIELD_W-1:0]);
        REG_LOCK:  lock = 64'(val[SPIN_W-1:0]);
        REG_SPIN:  spin = 64'(val[SPIN_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
      logic [128:0] t;
      t = {65'd0, a} * {65'd0, b} + (129'd1 << (s - 1));
      t = t >> s;
      return (t[128:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
    endfunction

    function logic [63:0] lorentzian(logic [63:0] x);
      logic [63:0] den;
      if (x >= 64'h8000_0000) den = 64'd1 << 63;
      else den = (64'd1 << 32) + x * x;
      return ((64'd1 << 63) + (den >> 1)) / den;
    endfunction

    function logic [63:0] sideband(logic [63:0] tau, int m);
      longint f;
      logic [63:0] fa;
      f = longint'(lock) + longint'(m) * longint'(spin);
      fa = (f < 0) ? -f : f;
      return lorentzian(mul_round(fa * tau, KS_Q64, 48));
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      t = a + b;
      return (t < a) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
    endfunction

    function logic [RATE_W-1:0] one_rate(logic [63:0] u, logic [63:0] dsum,
        logic [63:0] dcoef, logic [63:0] csum, logic [63:0] ccoef);
      logic [63:0] r;
      r = sat_sum(mul_round(mul_round(u, dsum, 31), dcoef, SH),
                  mul_round(mul_round(u, csum, 31), ccoef, SH));
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function void note(logic [TAU_BITS-1:0] tau_in, logic [S2_W-1:0] s2);
      logic [63:0] tau, q, u, p, xh, xn, lh, ln, ls, ld, s3, f2, d1, d2, c2;
      rates_t e;
      tau = 64'(tau_in);
      q = 64'd65536 - ((s2 > S2_ONE) ? 64'd65536 : 64'(s2));
      u = tau * q;
      p = field * tau;
      xh = mul_round(p, KH_Q48, 32);
      xn = mul_round(p, KN_Q48, 32);
      lh = lorentzian(xh);
      ln = lorentzian(xn);
      ls = lorentzian(xh + xn);
      ld = lorentzian((xh >= xn) ? xh - xn : 64'd0);
      s3 = 64'd2 * (sideband(tau, -2) + sideband(tau, 2))
         + 64'd4 * (sideband(tau, -1) + sideband(tau, 1));
      f2 = field * field;
      d1 = ld + 64'd3 * ln + 64'd6 * ls;
      d2 = s3 + 64'd9 * ln + 64'd3 * ld + 64'd18 * lh + 64'd18 * ls;
      c2 = s3 + 64'd9 * ln;
      e.r1 = one_rate(u, d1, A1_Q60, ln, B1_Q60 * f2);
      e.r2 = one_rate(u, d2, A2_Q60, c2, B2_Q60 * f2);
      pending.push_back(e);
    endfunction

    function void check(logic [RATE_W-1:0] r1, logic [RATE_W-1:0] r2);
      rates_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word r1=%h r2=%h", r1, r2);
        return;
      end
      e = pending.pop_front();
      if (e.r1 !== r1 || e.r2 !== r2) begin
        errors++;
        if (errors <= 10)
          $display("mismatch r1 exp %h got %h, r2 exp %h got %h", e.r1, r1, e.r2, r2);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [TAU_BITS-1:0] in_tau_ps = 0;
  logic [S2_W-1:0] in_order_param = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [RATE_W-1:0] out_r1_rate, out_r2_rate;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = REG_FIELD;
  logic [CFG_W-1:0] cfg_data = 0;

  rate_board board = new();
  int cycles = 0;
  bit calm = 0;

  nh_model_free_relaxation_rates u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) board.note(in_tau_ps, in_order_param);
    if (rst_n && out_valid && !out_stall) board.check(out_r1_rate, out_r2_rate);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int n;
    forever begin
      n = pick_gap();
      @(negedge clk);
      out_stall = (n != 0);
      repeat (n) @(negedge clk);
      out_stall = 0;
    end
  end

  task automatic send(logic [TAU_BITS-1:0] tau, logic [S2_W-1:0] s2);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    in_tau_ps = tau;
    in_order_param = s2;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (LOR_LAT + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_words(int count);
    logic [TAU_BITS-1:0] tau;
    logic [S2_W-1:0] s2;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: tau = TAU_BITS'($urandom_range(0, 20000));
        1: tau = TAU_BITS'($urandom_range(0, 1000000));
        2: tau = TAU_BITS'($urandom);
        default: tau = TAU_BITS'($urandom_range(0, 3000));
      endcase
      s2 = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      send(tau, s2);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1;

    calm = 1;
    send(0, 0);
    send(20'd1000000, 0);
    send(20'hFFFFF, 0);
    send(5000, S2_ONE);
    send(5000, 17'd65537);
    send(5000, 17'h1FFFF);
    send(1, 1);
    send(10000, 17'd32768);
    send(100000, 17'd52000);
    send(500, 17'h0AAAA);
    calm = 0;
    drain();

    write_reg(REG_FIELD, 18'd1200);
    write_reg(REG_LOCK, 18'd200000);
    write_reg(REG_SPIN, 18'd200000);
    write_reg(REG_SPARE, 18'h3FFFF);
    send(0, 0);
    send(20'hFFFFF, 0);
    send(20'h55555, 17'h15555);
    send(50, 17'd65535);
    send(2000, 0);
    send(20'd1000000, 17'd65536);
    random_words(150);
    drain();

    write_reg(REG_FIELD, 18'h3FFFF);
    write_reg(REG_LOCK, 18'd0);
    write_reg(REG_SPIN, 18'h3FFFF);
    calm = 1;
    random_words(60);
    calm = 0;
    random_words(90);
    drain();

    write_reg(REG_FIELD, 18'd0);
    write_reg(REG_LOCK, 18'd100000);
    write_reg(REG_SPIN, 18'd150000);
    send(20'hFFFFF, 0);
    random_words(120);
    drain();

    write_reg(REG_FIELD, CFG_W'($urandom_range(1, 1200)));
    write_reg(REG_LOCK, CFG_W'($urandom_range(0, 200000)));
    write_reg(REG_SPIN, CFG_W'($urandom_range(0, 200000)));
    random_words(200);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
